// ----- rtl/core/threshold_centroid_radius_detect_unit_macros.svh -----
// Assertion macros shared by the blob detector RTL.
`ifndef THRESHOLD_CENTROID_RADIUS_DETECT_UNIT_MACROS_SVH
`define THRESHOLD_CENTROID_RADIUS_DETECT_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TCRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define TCRD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/tcrd_pkg.sv -----
// Shared types and constants of the blob centroid and radius detector.
`default_nettype none

package tcrd_pkg;

  // Field and port widths
  localparam int unsigned PIXEL_W    = 8;
  localparam int unsigned OUT_W      = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  // Register reset values
  localparam logic [PIXEL_W-1:0]    THRESHOLD_RESET = 8'd0;
  localparam logic [CFG_DATA_W-1:0] FRAME_DIM_RESET = 10'd400;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;      // pixel word taken this cycle
    logic div_start;   // launch a division
    logic div_sel;     // 0: column sum, 1: row sum
    logic walk_init;   // start the row walk at the center column
    logic walk_adv;    // step the walk one column right
    logic walk_found;  // hit map bit at the walk column is set
    logic emit;        // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_pixel;  // current position is the last of the frame
    logic any_hit;     // frame has at least one hit
    logic div_done;    // quotient ready
    logic map_hit;     // registered hit map bit
    logic walk_end;    // walk column is the last column
    logic out_free;    // result register can take a new word
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/threshold_centroid_radius_detect_unit.sv -----
// Top level of the thresholded blob centroid and radius detector.
`default_nettype none

// Takes one frame in raster order, one pixel word per cycle, and counts the
// position internally. Pixels strictly above the threshold add their column
// and row to running sums and set their bit in an on-chip hit map of
// MAX_DIM x MAX_DIM bits. While a frame streams in, a pixel is taken every
// cycle. After the last pixel the input stalls while the centroid and radius
// are worked out and while an earlier result word still sits untaken in the
// output register: the centroid comes from one shared divider that makes one
// quotient bit per cycle (run once for the column and once for the row), and
// the walk along the center row reads the hit map with a registered read,
// alternating a read state and a check state for each column up to the first
// hit. A frame with no hits skips both, passing only through the check and
// emit states, and reports detected 0. The result word sits in an output
// register, so the next frame may start streaming while it waits to be taken.
// Writing frame_width or frame_height clears the raster position and the
// running sums. The hit map needs no clearing pass after reset.
module threshold_centroid_radius_detect_unit #(
  parameter int unsigned MAX_DIM = 512
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tcrd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tcrd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           pixel_valid_i,
  output logic                                pixel_stall_o,
  input  wire logic [tcrd_pkg::PIXEL_W-1:0]    pixel_i,
  output logic                                result_valid_o,
  input  wire logic                           result_stall_i,
  output logic [tcrd_pkg::OUT_W-1:0]          center_x_o,
  output logic [tcrd_pkg::OUT_W-1:0]          center_y_o,
  output logic [tcrd_pkg::OUT_W-1:0]          radius_o,
  output logic                                detected_o
);

  tcrd_pkg::cmd_t cmd;
  tcrd_pkg::sts_t sts;

  tcrd_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_i        (pixel_i),
    .result_stall_i (result_stall_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .center_x_o     (center_x_o),
    .center_y_o     (center_y_o),
    .radius_o       (radius_o),
    .detected_o     (detected_o)
  );

  tcrd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_valid_i (pixel_valid_i),
    .pixel_stall_o (pixel_stall_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

endmodule

`default_nettype wire

// ----- rtl/core/tcrd_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module tcrd_div #(
  parameter int unsigned NW = 27,
  parameter int unsigned DW = 19,
  parameter int unsigned QW = 9
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic [QW-1:0]      quot_o
);

  localparam int unsigned IW = (QW > 1) ? $clog2(QW) : 1;

  logic          busy_q;
  logic          done_q;
  logic [IW-1:0] idx_q;
  logic [NW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [QW-1:0] quot_q;
  logic [NW-1:0] shifted;
  logic          fits;

  // Trial subtract of the divisor aligned to the current quotient bit
  assign shifted = NW'(den_q) << idx_q;
  assign fits    = rem_q >= shifted;

  // Sequence the bit steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      idx_q  <= IW'(QW - 1);
    end else if (busy_q) begin
      if (idx_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        idx_q <= idx_q - IW'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Hold operands, update remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      den_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - shifted;
      end
      quot_q[idx_q] <= fits;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- rtl/core/tcrd_datapath.sv -----
// Datapath: registers, position counters, sums, hit map, divider and result register.
`default_nettype none

`include "threshold_centroid_radius_detect_unit_macros.svh"

module tcrd_datapath #(
  parameter int unsigned MAX_DIM = 512
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tcrd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tcrd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [tcrd_pkg::PIXEL_W-1:0]    pixel_i,
  input  wire logic                           result_stall_i,
  input  wire tcrd_pkg::cmd_t                 cmd_i,
  output tcrd_pkg::sts_t                      sts_o,
  output logic                                result_valid_o,
  output logic [tcrd_pkg::OUT_W-1:0]          center_x_o,
  output logic [tcrd_pkg::OUT_W-1:0]          center_y_o,
  output logic [tcrd_pkg::OUT_W-1:0]          radius_o,
  output logic                                detected_o
);

  localparam int unsigned CW   = $clog2(MAX_DIM);      // coordinate bits
  localparam int unsigned DW   = $clog2(MAX_DIM + 1);  // dimension bits
  localparam int unsigned SW   = 3 * CW;               // coordinate sum bits
  localparam int unsigned NCW  = 2 * CW + 1;           // hit count bits
  localparam int unsigned AW   = 2 * CW;               // hit map address bits
  localparam int unsigned MAP_DEPTH = 1 << AW;

  // Clamp a written dimension into 1 .. MAX_DIM
  function automatic logic [DW-1:0] eff_dim(logic [tcrd_pkg::CFG_DATA_W-1:0] v);
    if (v == '0) begin
      eff_dim = DW'(1);
    end else if (32'(v) > MAX_DIM) begin
      eff_dim = DW'(MAX_DIM);
    end else begin
      eff_dim = DW'(v);
    end
  endfunction

  logic [tcrd_pkg::PIXEL_W-1:0] thr_q;
  logic [DW-1:0]  width_q;
  logic [DW-1:0]  height_q;
  logic [CW-1:0]  col_q;
  logic [CW-1:0]  row_q;
  logic [SW-1:0]  col_sum_q;
  logic [SW-1:0]  row_sum_q;
  logic [NCW-1:0] cnt_q;
  logic           div_sel_q;
  logic [CW-1:0]  cx_q;
  logic [CW-1:0]  cy_q;
  logic [CW-1:0]  x_q;
  logic [CW-1:0]  rad_q;
  logic           map_q;
  logic           map_mem [MAP_DEPTH];
  logic           result_valid_q;
  logic [tcrd_pkg::OUT_W-1:0] center_x_q;
  logic [tcrd_pkg::OUT_W-1:0] center_y_q;
  logic [tcrd_pkg::OUT_W-1:0] radius_q;
  logic           detected_q;

  logic           hit;
  logic           last_col;
  logic           last_row;
  logic           restart;
  logic           any_hit;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic [SW-1:0]  div_num;
  logic           div_done;
  logic [CW-1:0]  div_quot;

  assign hit      = pixel_i > thr_q;
  assign last_col = (DW'(col_q) + DW'(1)) == width_q;
  assign last_row = (DW'(row_q) + DW'(1)) == height_q;
  assign restart  = cfg_we_i && (cfg_idx_i == tcrd_pkg::CFG_FRAME_WIDTH ||
                                 cfg_idx_i == tcrd_pkg::CFG_FRAME_HEIGHT);
  assign any_hit  = cnt_q != '0;
  assign wr_addr  = {row_q, col_q};
  assign rd_addr  = {cy_q, x_q};
  assign div_num  = cmd_i.div_sel ? row_sum_q : col_sum_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= tcrd_pkg::THRESHOLD_RESET;
      width_q  <= eff_dim(tcrd_pkg::FRAME_DIM_RESET);
      height_q <= eff_dim(tcrd_pkg::FRAME_DIM_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcrd_pkg::CFG_THRESHOLD:    thr_q    <= cfg_data_i[tcrd_pkg::PIXEL_W-1:0];
        tcrd_pkg::CFG_FRAME_WIDTH:  width_q  <= eff_dim(cfg_data_i);
        tcrd_pkg::CFG_FRAME_HEIGHT: height_q <= eff_dim(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Advance the raster position and accumulate hits; clear on restart or emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      col_sum_q <= '0;
      row_sum_q <= '0;
      cnt_q     <= '0;
    end else if (restart) begin
      col_q     <= '0;
      row_q     <= '0;
      col_sum_q <= '0;
      row_sum_q <= '0;
      cnt_q     <= '0;
    end else if (cmd_i.accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + CW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
      if (hit) begin
        col_sum_q <= col_sum_q + SW'(col_q);
        row_sum_q <= row_sum_q + SW'(row_q);
        cnt_q     <= cnt_q + NCW'(1);
      end
    end else if (cmd_i.emit) begin
      col_sum_q <= '0;
      row_sum_q <= '0;
      cnt_q     <= '0;
    end
  end

  // Hit map: write on each pixel, registered read for the walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      map_mem[wr_addr] <= hit;
    end
    map_q <= map_mem[rd_addr];
  end

  // Shared divider for both centroid coordinates
  tcrd_div #(
    .NW (SW),
    .DW (NCW),
    .QW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Capture quotients and run the row walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_sel_q <= cmd_i.div_sel;
    end
    if (div_done) begin
      if (div_sel_q) begin
        cy_q <= div_quot;
      end else begin
        cx_q <= div_quot;
      end
    end
    if (cmd_i.walk_init) begin
      x_q   <= cx_q;
      rad_q <= '0;
    end else if (cmd_i.walk_adv) begin
      x_q <= x_q + CW'(1);
    end else if (cmd_i.walk_found) begin
      rad_q <= x_q - cx_q;
    end
  end

  // Result register: set on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      result_valid_q <= 1'b1;
    end else if (!result_stall_i) begin
      result_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      center_x_q <= any_hit ? tcrd_pkg::OUT_W'(cx_q) : '0;
      center_y_q <= any_hit ? tcrd_pkg::OUT_W'(cy_q) : '0;
      radius_q   <= any_hit ? tcrd_pkg::OUT_W'(rad_q) : '0;
      detected_q <= any_hit;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.last_pixel = last_col && last_row;
    sts_o.any_hit    = any_hit;
    sts_o.div_done   = div_done;
    sts_o.map_hit    = map_q;
    sts_o.walk_end   = (DW'(x_q) + DW'(1)) == width_q;
    sts_o.out_free   = !result_valid_q || !result_stall_i;
  end

  assign result_valid_o = result_valid_q;
  assign center_x_o     = center_x_q;
  assign center_y_o     = center_y_q;
  assign radius_o       = radius_q;
  assign detected_o     = detected_q;

  `TCRD_ASSERT(a_pos_in_frame, (DW'(col_q) < width_q) && (DW'(row_q) < height_q), "raster position outside the frame")
  `TCRD_ASSERT(a_valid_from_emit, $rose(result_valid_q) |-> $past(cmd_i.emit), "result word raised without an emit")
  `TCRD_ASSERT(a_walk_in_row, cmd_i.walk_found |-> (DW'(x_q) < width_q) && (x_q >= cx_q), "walk hit outside the center row span")

endmodule

`default_nettype wire

// ----- rtl/core/tcrd_ctrl.sv -----
// Controller: frame intake, division sequencing, row walk and result hand-off.
`default_nettype none

`include "threshold_centroid_radius_detect_unit_macros.svh"

module tcrd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           pixel_valid_i,
  output logic                pixel_stall_o,
  input  wire tcrd_pkg::sts_t sts_i,
  output tcrd_pkg::cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    ST_ACCUM   = 7'b0000001,
    ST_CHK     = 7'b0000010,
    ST_DIVX    = 7'b0000100,
    ST_DIVY    = 7'b0001000,
    ST_WALK_RD = 7'b0010000,
    ST_WALK_CK = 7'b0100000,
    ST_EMIT    = 7'b1000000
  } state_e;

  state_e state_q;
  state_e state_d;

  // Take pixel words only while gathering a frame
  assign pixel_stall_o = state_q != ST_ACCUM;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_ACCUM: begin
        cmd_o.accept = pixel_valid_i;
        if (pixel_valid_i && sts_i.last_pixel) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (sts_i.any_hit) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b0;
          state_d         = ST_DIVX;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIVX: begin
        if (sts_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 1'b1;
          state_d         = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (sts_i.div_done) begin
          cmd_o.walk_init = 1'b1;
          state_d         = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        state_d = ST_WALK_CK;
      end
      ST_WALK_CK: begin
        if (sts_i.map_hit) begin
          cmd_o.walk_found = 1'b1;
          state_d          = ST_EMIT;
        end else if (sts_i.walk_end) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.walk_adv = 1'b1;
          state_d        = ST_WALK_RD;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  `TCRD_ASSERT(a_state_onehot, $onehot(state_q), "controller state not one-hot")
  `TCRD_ASSERT(a_div_done_state, sts_i.div_done |-> (state_q == ST_DIVX || state_q == ST_DIVY), "divider done outside a divide state")
  `TCRD_ASSERT(a_check_after_read, (state_q == ST_WALK_CK) |-> $past(state_q == ST_WALK_RD), "hit map checked without a read")

endmodule

`default_nettype wire
